[sv/fbrgb_pkg.sv]
// ---------------------------------------------------------------------------
// fbrgb_pkg
// Shared types, codes and constants of the framebuffer pixel unpacker.
// ---------------------------------------------------------------------------
package fbrgb_pkg;

   // Defaults for the top-level parameters
   localparam int PALETTE_ENTRIES_DEFAULT = 256;
   localparam int MAX_WIDTH_DEFAULT       = 2560;
   localparam int MAX_HEIGHT_DEFAULT      = 1600;

   // Result queue behind the palette read stage
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LVL_W  = QUEUE_PTR_W + 1;

   // Fixed field widths
   localparam int PIXEL_X_W    = 12;
   localparam int ROW_COUNT_W  = 11;
   localparam int BYTE_ROW_W   = 14;
   localparam int CSR_DATA_W   = 14;
   localparam int CSR_INDEX_W  = 2;

   // Request kinds
   localparam logic REQ_FB_BYTE       = 1'b0;
   localparam logic REQ_PALETTE_WRITE = 1'b1;

   // Depth modes
   localparam logic [2:0] MODE_1BPP     = 3'd0;
   localparam logic [2:0] MODE_2BPP     = 3'd1;
   localparam logic [2:0] MODE_4BPP     = 3'd2;
   localparam logic [2:0] MODE_8BPP     = 3'd3;
   localparam logic [2:0] MODE_RGB555   = 3'd4;
   localparam logic [2:0] MODE_ARGB8888 = 3'd5;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_STRIDE   = 2'd3;

   // Configuration register reset values
   localparam logic [2:0]             DEPTH_MODE_RESET   = MODE_ARGB8888;
   localparam logic [PIXEL_X_W-1:0]   FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [ROW_COUNT_W-1:0] FRAME_HEIGHT_RESET = 11'd480;
   localparam logic [BYTE_ROW_W-1:0]  ROW_STRIDE_RESET   = 14'd2560;

   typedef struct packed {
      logic       req_type;
      logic [7:0] source_byte;
      logic [7:0] entry_index;
      logic [7:0] entry_red;
      logic [7:0] entry_green;
      logic [7:0] entry_blue;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       run_last;
      logic       row_end;
      logic       frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0]             depth_mode;
      logic [PIXEL_X_W-1:0]   active_width;
      logic [ROW_COUNT_W-1:0] active_height;
      logic [BYTE_ROW_W-1:0]  row_stride_bytes;
   } cfg_type;

   // One pixel on its way to the palette read port
   typedef struct packed {
      logic        valid;
      logic        lookup;     // color comes from the palette
      logic [7:0]  index;
      logic [23:0] rgb;        // direct color for the true-color modes
      logic        run_last;
      logic        row_end;
      logic        frame_end;
   } pix_op_type;

   typedef struct packed {
      logic        en;
      logic [7:0]  index;
      logic [23:0] rgb;
   } pal_wr_type;

   // Gray level 255 - i for an entry that was never written
   function automatic logic [23:0] palette_reset_rgb(input logic [7:0] idx);
      logic [7:0] g;
      g = ~idx;
      return {g, g, g};
   endfunction

endpackage

[sv/fbrgb_palette.sv]
// ---------------------------------------------------------------------------
// fbrgb_palette
// Palette RAM with one write and one registered read port per cycle.
// ---------------------------------------------------------------------------
module fbrgb_palette #(
   parameter int PALETTE_ENTRIES = fbrgb_pkg::PALETTE_ENTRIES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fbrgb_pkg::pix_op_type      pix_op,
   input  fbrgb_pkg::pal_wr_type      pal_wr,
   output logic                       push_valid,
   output fbrgb_pkg::rsp_payload_type push_data
);

   localparam int AddrW = $clog2(PALETTE_ENTRIES);

   logic [23:0]                palette_mem_ff [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] entry_valid_ff;
   logic [PALETTE_ENTRIES-1:0] entry_valid_in;

   logic                  wr_in_range;
   logic                  rd_in_range;
   logic [AddrW-1:0]      wr_addr;
   logic [AddrW-1:0]      rd_addr;

   logic                  rd_valid_ff;
   fbrgb_pkg::pix_op_type rd_op_ff;
   logic [23:0]           rd_data_ff;
   logic                  rd_written_ff;
   logic                  rd_in_range_ff;
   logic [23:0]           rgb;

   assign wr_in_range = {1'b0, pal_wr.index} < 9'(PALETTE_ENTRIES);
   assign rd_in_range = {1'b0, pix_op.index} < 9'(PALETTE_ENTRIES);
   assign wr_addr     = pal_wr.index[AddrW-1:0];
   assign rd_addr     = pix_op.index[AddrW-1:0];

   always_ff @(posedge clock) begin
      if (pal_wr.en && wr_in_range) begin
         palette_mem_ff[wr_addr] <= pal_wr.rgb;
      end
   end

   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (pal_wr.en && wr_in_range) begin
         entry_valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         rd_valid_ff    <= pix_op.valid;
      end
   end

   always_ff @(posedge clock) begin
      rd_op_ff       <= pix_op;
      rd_data_ff     <= palette_mem_ff[rd_addr];
      rd_written_ff  <= entry_valid_ff[rd_addr];
      rd_in_range_ff <= rd_in_range;
   end

   // Direct colors pass through; unwritten entries read as their reset gray; out-of-range reads as black
   always_comb begin
      if (!rd_op_ff.lookup) begin
         rgb = rd_op_ff.rgb;
      end else if (!rd_in_range_ff) begin
         rgb = 24'h000000;
      end else if (!rd_written_ff) begin
         rgb = fbrgb_pkg::palette_reset_rgb(rd_op_ff.index);
      end else begin
         rgb = rd_data_ff;
      end
   end

   assign push_valid          = rd_valid_ff;
   assign push_data.red       = rgb[23:16];
   assign push_data.green     = rgb[15:8];
   assign push_data.blue      = rgb[7:0];
   assign push_data.run_last  = rd_op_ff.run_last;
   assign push_data.row_end   = rd_op_ff.row_end;
   assign push_data.frame_end = rd_op_ff.frame_end;

endmodule

[sv/fbrgb_sequencer.sv]
// ---------------------------------------------------------------------------
// fbrgb_sequencer
// Holds one request, steps out its pixels and keeps the raster counters.
// ---------------------------------------------------------------------------
module fbrgb_sequencer #(
   parameter int MAX_WIDTH  = fbrgb_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = fbrgb_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  fbrgb_pkg::req_payload_type req_payload,
   input  fbrgb_pkg::cfg_type         cfg,
   input  logic                       credit_ok,
   output fbrgb_pkg::pix_op_type      pix_op,
   output fbrgb_pkg::pal_wr_type      pal_wr
);

   localparam int XW = fbrgb_pkg::PIXEL_X_W;
   localparam int YW = fbrgb_pkg::ROW_COUNT_W;
   localparam int BW = fbrgb_pkg::BYTE_ROW_W;

   logic                       cur_valid_ff, cur_valid_in;
   fbrgb_pkg::req_payload_type cur_ff;
   logic [7:0]                 shift_ff, shift_in;
   logic [2:0]                 k_ff, k_in;
   logic [XW-1:0]              pixel_x_ff, pixel_x_in;
   logic [BW-1:0]              byte_in_row_ff, byte_in_row_in;
   logic [YW-1:0]              row_count_ff, row_count_in;
   logic [23:0]                held_ff, held_in;
   logic [1:0]                 phase_ff, phase_in;

   logic [XW-1:0] eff_w;
   logic [YW-1:0] eff_h;
   logic          is_write;
   logic          step;
   logic          visible;
   logic          at_edge;
   logic          produce;
   logic          done_byte;
   logic          finishing;
   logic          accept;
   logic          fire_pix;
   logic          row_wrap;
   logic          indexed;
   logic [7:0]    idx;
   logic [7:0]    shift_next;
   logic          last_k;
   logic [23:0]   direct_rgb;
   logic [15:0]   p555;
   logic [23:0]   held_mode;
   logic [1:0]    phase_mode;

   assign eff_w = ({1'b0, cfg.active_width} > (XW + 1)'(MAX_WIDTH))
                  ? XW'(MAX_WIDTH) : cfg.active_width;
   assign eff_h = ({1'b0, cfg.active_height} > (YW + 1)'(MAX_HEIGHT))
                  ? YW'(MAX_HEIGHT) : cfg.active_height;

   assign is_write = cur_ff.req_type == fbrgb_pkg::REQ_PALETTE_WRITE;
   assign step     = cur_valid_ff && (is_write || credit_ok);
   assign visible  = pixel_x_ff < eff_w;
   assign at_edge  = ({1'b0, pixel_x_ff} + (XW + 1)'(1)) == {1'b0, eff_w};
   assign p555     = {held_ff[7:0], cur_ff.source_byte};

   // Per-mode pixel selection and multi-byte gathering
   always_comb begin
      indexed    = 1'b0;
      idx        = 8'h00;
      shift_next = shift_ff;
      last_k     = 1'b1;
      produce    = 1'b0;
      done_byte  = 1'b1;
      direct_rgb = 24'h000000;
      held_mode  = held_ff;
      phase_mode = phase_ff;
      case (cfg.depth_mode)
         fbrgb_pkg::MODE_1BPP: begin
            indexed    = 1'b1;
            idx        = {7'b0, shift_ff[7]};
            shift_next = {shift_ff[6:0], 1'b0};
            last_k     = k_ff == 3'd7;
         end
         fbrgb_pkg::MODE_2BPP: begin
            indexed    = 1'b1;
            idx        = {6'b0, shift_ff[7:6]};
            shift_next = {shift_ff[5:0], 2'b00};
            last_k     = k_ff == 3'd3;
         end
         fbrgb_pkg::MODE_4BPP: begin
            indexed    = 1'b1;
            idx        = {4'b0, shift_ff[7:4]};
            shift_next = {shift_ff[3:0], 4'b0000};
            last_k     = k_ff == 3'd1;
         end
         fbrgb_pkg::MODE_8BPP: begin
            indexed = 1'b1;
            idx     = shift_ff;
            last_k  = 1'b1;
         end
         fbrgb_pkg::MODE_RGB555: begin
            if (phase_ff == 2'd0) begin
               held_mode  = {16'h0000, cur_ff.source_byte};
               phase_mode = 2'd1;
            end else begin
               produce    = visible;
               direct_rgb = {p555[14:10], 3'b000, p555[9:5], 3'b000, p555[4:0], 3'b000};
               held_mode  = 24'h000000;
               phase_mode = 2'd0;
            end
         end
         fbrgb_pkg::MODE_ARGB8888: begin
            case (phase_ff)
               2'd0: begin
                  held_mode  = 24'h000000;
                  phase_mode = 2'd1;
               end
               2'd1: begin
                  held_mode  = {cur_ff.source_byte, 16'h0000};
                  phase_mode = 2'd2;
               end
               2'd2: begin
                  held_mode  = {held_ff[23:16], cur_ff.source_byte, 8'h00};
                  phase_mode = 2'd3;
               end
               default: begin
                  produce    = visible;
                  direct_rgb = {held_ff[23:8], cur_ff.source_byte};
                  held_mode  = 24'h000000;
                  phase_mode = 2'd0;
               end
            endcase
         end
         default: begin
            produce = 1'b0;
         end
      endcase
      if (indexed) begin
         produce   = visible;
         done_byte = last_k || !visible || at_edge;
      end
   end

   assign fire_pix  = step && !is_write && produce;
   assign finishing = step && (is_write || done_byte);
   assign req_stall = cur_valid_ff && !finishing;
   assign accept    = req_valid && !req_stall;
   assign row_wrap  = step && !is_write && done_byte &&
                      (({1'b0, byte_in_row_ff} + (BW + 1)'(1)) >=
                       {1'b0, cfg.row_stride_bytes});

   always_comb begin
      cur_valid_in   = cur_valid_ff;
      shift_in       = shift_ff;
      k_in           = k_ff;
      pixel_x_in     = pixel_x_ff;
      byte_in_row_in = byte_in_row_ff;
      row_count_in   = row_count_ff;
      held_in        = held_ff;
      phase_in       = phase_ff;

      if (finishing) begin
         cur_valid_in = 1'b0;
      end
      if (accept) begin
         cur_valid_in = 1'b1;
         shift_in     = req_payload.source_byte;
         k_in         = 3'd0;
      end else if (step && !finishing) begin
         // advance to the next pixel of the same byte
         shift_in = shift_next;
         k_in     = k_ff + 3'd1;
      end

      if (fire_pix) begin
         pixel_x_in = pixel_x_ff + XW'(1);
      end

      if (step && !is_write) begin
         held_in  = held_mode;
         phase_in = phase_mode;
      end

      if (row_wrap) begin
         byte_in_row_in = '0;
         pixel_x_in     = '0;
         phase_in       = 2'd0;
         held_in        = 24'h000000;
         if (({1'b0, row_count_ff} + (YW + 1)'(1)) >= {1'b0, eff_h}) begin
            row_count_in = '0;
         end else begin
            row_count_in = row_count_ff + YW'(1);
         end
      end else if (step && !is_write && done_byte) begin
         byte_in_row_in = byte_in_row_ff + BW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff   <= 1'b0;
         pixel_x_ff     <= '0;
         byte_in_row_ff <= '0;
         row_count_ff   <= '0;
         held_ff        <= 24'h000000;
         phase_ff       <= 2'd0;
      end else begin
         cur_valid_ff   <= cur_valid_in;
         pixel_x_ff     <= pixel_x_in;
         byte_in_row_ff <= byte_in_row_in;
         row_count_ff   <= row_count_in;
         held_ff        <= held_in;
         phase_ff       <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff <= req_payload;
      end
      shift_ff <= shift_in;
      k_ff     <= k_in;
   end

   always_comb begin
      pix_op.valid     = fire_pix;
      pix_op.lookup    = indexed;
      pix_op.index     = idx;
      pix_op.rgb       = direct_rgb;
      pix_op.run_last  = done_byte;
      pix_op.row_end   = at_edge;
      pix_op.frame_end = at_edge &&
                         (({1'b0, row_count_ff} + (YW + 1)'(1)) == {1'b0, eff_h});
      pal_wr.en        = step && is_write;
      pal_wr.index     = cur_ff.entry_index;
      pal_wr.rgb       = {cur_ff.entry_red, cur_ff.entry_green, cur_ff.entry_blue};
   end

endmodule

[sv/fbrgb_rsp_queue.sv]
// ---------------------------------------------------------------------------
// fbrgb_rsp_queue
// Small result queue that decouples the pipeline from output stalls.
// ---------------------------------------------------------------------------
module fbrgb_rsp_queue (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push_valid,
   input  fbrgb_pkg::rsp_payload_type            push_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output fbrgb_pkg::rsp_payload_type            rsp_payload,
   output logic [fbrgb_pkg::QUEUE_LVL_W-1:0]     level
);

   localparam int PW = fbrgb_pkg::QUEUE_PTR_W;
   localparam int LW = fbrgb_pkg::QUEUE_LVL_W;

   fbrgb_pkg::rsp_payload_type slot_ff [fbrgb_pkg::QUEUE_DEPTH];
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [LW-1:0] level_ff, level_in;
   logic          pop;

   assign rsp_valid   = level_ff != '0;
   assign rsp_payload = slot_ff[head_ff];
   assign pop         = rsp_valid && !rsp_stall;
   assign level       = level_ff;

   always_comb begin
      head_in  = pop ? head_ff + PW'(1) : head_ff;
      tail_in  = push_valid ? tail_ff + PW'(1) : tail_ff;
      level_in = level_ff + LW'(push_valid) - LW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

endmodule

[sv/framebuffer_to_rgb_pixel_unpacker_unit.sv]
// ---------------------------------------------------------------------------
// framebuffer_to_rgb_pixel_unpacker_unit
// Turns framebuffer bytes into RGB pixels, through a 24-bit color palette in the indexed modes.
// ---------------------------------------------------------------------------
//
//   Channel | Direction | Handshake          | Transfer
//   --------+-----------+--------------------+---------------------------------
//   req_    | in        | req_valid/req_stall| framebuffer byte or palette write
//   rsp_    | out       | rsp_valid/rsp_stall| one RGB pixel with run/row/frame
//   csr_    | in        | csr_write_enable   | one configuration register write
//
// Pixels leave at up to one per cycle while rsp_ and the result queue allow,
// paced by the single palette read port. The sequencer steps a framebuffer
// byte out one visible pixel at a time (up to 8 at 1 bpp), in a single step if
// it yields none; a palette write takes a single step. An issued pixel passes
// the palette RAM read register, then the result queue, before it reaches rsp_.
// Reset is synchronous; entry valid bits give the gray ramp with no clearing.
// Output stalls fill a four-entry queue, then hold the sequencer and req_.
module framebuffer_to_rgb_pixel_unpacker_unit #(
   parameter int PALETTE_ENTRIES = fbrgb_pkg::PALETTE_ENTRIES_DEFAULT,
   parameter int MAX_WIDTH       = fbrgb_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT      = fbrgb_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  fbrgb_pkg::req_payload_type          req_payload,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output fbrgb_pkg::rsp_payload_type          rsp_payload,
   // configuration port
   input  logic                                csr_write_enable,
   input  logic [fbrgb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fbrgb_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   fbrgb_pkg::cfg_type               cfg_ff;
   fbrgb_pkg::pix_op_type            pix_op;
   fbrgb_pkg::pal_wr_type            pal_wr;
   logic                             push_valid;
   fbrgb_pkg::rsp_payload_type       push_data;
   logic [fbrgb_pkg::QUEUE_LVL_W-1:0] q_level;
   logic                             credit_ok;

   // Configuration registers: to be written only while the block is idle; the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_mode       <= fbrgb_pkg::DEPTH_MODE_RESET;
         cfg_ff.active_width     <= fbrgb_pkg::FRAME_WIDTH_RESET;
         cfg_ff.active_height    <= fbrgb_pkg::FRAME_HEIGHT_RESET;
         cfg_ff.row_stride_bytes <= fbrgb_pkg::ROW_STRIDE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            fbrgb_pkg::CSR_DEPTH_MODE: begin
               cfg_ff.depth_mode <= csr_write_data[2:0];
            end
            fbrgb_pkg::CSR_FRAME_WIDTH: begin
               cfg_ff.active_width <= csr_write_data[fbrgb_pkg::PIXEL_X_W-1:0];
            end
            fbrgb_pkg::CSR_FRAME_HEIGHT: begin
               cfg_ff.active_height <= csr_write_data[fbrgb_pkg::ROW_COUNT_W-1:0];
            end
            fbrgb_pkg::CSR_ROW_STRIDE: begin
               cfg_ff.row_stride_bytes <= csr_write_data[fbrgb_pkg::BYTE_ROW_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Issue a pixel only when the queue can absorb it together with the one
   // already in the palette read stage; drop back as soon as it cannot.
   assign credit_ok = ({1'b0, q_level} + (fbrgb_pkg::QUEUE_LVL_W + 1)'(push_valid))
                      < (fbrgb_pkg::QUEUE_LVL_W + 1)'(fbrgb_pkg::QUEUE_DEPTH);

   fbrgb_sequencer #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .credit_ok   (credit_ok),
      .pix_op      (pix_op),
      .pal_wr      (pal_wr)
   );

   // Palette lookup: read issued with the pixel, read data registered
   fbrgb_palette #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_palette (
      .clock      (clock),
      .reset      (reset),
      .pix_op     (pix_op),
      .pal_wr     (pal_wr),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // Result queue: hold finished pixels while rsp_ is stalled
   fbrgb_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_data   (push_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .level       (q_level)
   );

   // Queue never receives a pixel while it is full
   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (q_level != fbrgb_pkg::QUEUE_LVL_W'(fbrgb_pkg::QUEUE_DEPTH)))
      else $error("result queue overflow");

   // An issued pixel arrives at the queue input on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      pix_op.valid |=> push_valid)
      else $error("palette stage lost a pixel");

   // No pixel issued without queue credit
   assert property (@(posedge clock) disable iff (reset)
      pix_op.valid |-> credit_ok)
      else $error("pixel issued without queue credit");

   // Palette writes and pixel issue never share a cycle
   assert property (@(posedge clock) disable iff (reset)
      !(pix_op.valid && pal_wr.en))
      else $error("palette write collided with a pixel read");

endmodule

[test/framebuffer_to_rgb_pixel_unpacker_unit_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// framebuffer_to_rgb_pixel_unpacker_unit_tb
// Self-checking bench for the framebuffer pixel unpacker. A behavioral
// predictor computes the pixels of every accepted request; a clocked monitor
// compares each result transfer against the oldest predicted pixel. A short
// directed sequence covers every depth mode and corner of the row and frame
// counters, a short run sets width and height above their caps, and random
// formats with random traffic and random idling on both channels follow.
// ---------------------------------------------------------------------------
module framebuffer_to_rgb_pixel_unpacker_unit_tb;

   localparam int PALETTE_ENTRIES = fbrgb_pkg::PALETTE_ENTRIES_DEFAULT;
   localparam int MAX_WIDTH       = fbrgb_pkg::MAX_WIDTH_DEFAULT;
   localparam int MAX_HEIGHT      = fbrgb_pkg::MAX_HEIGHT_DEFAULT;

   // Depth codes the block consumes but never turns into pixels
   localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
   localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

   localparam int RESET_CYCLES  = 6;
   localparam int IDLE_PCT      = 24;
   // Time for the sequencer, palette read and result queue to settle
   localparam int SETTLE_CYCLES = 12;
   localparam int LIMIT_CYCLES  = 500000;
   localparam int CALM_START    = 600;
   localparam int CALM_END      = 3000;
   localparam int RANDOM_ITEMS  = 310;
   localparam int MAX_REPORTS   = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   fbrgb_pkg::req_payload_type req_payload = '0;

   logic                       rsp_valid;
   logic                       rsp_stall   = 1'b0;
   fbrgb_pkg::rsp_payload_type rsp_payload;

   logic                              csr_write_enable = 1'b0;
   logic [fbrgb_pkg::CSR_INDEX_W-1:0] csr_index        = '0;
   logic [fbrgb_pkg::CSR_DATA_W-1:0]  csr_write_data   = '0;

   // Requests waiting to go out, and pixels the block still owes us
   fbrgb_pkg::req_payload_type req_backlog [$];
   fbrgb_pkg::rsp_payload_type pixels_due  [$];

   int  error_count = 0;
   int  cycle_count = 0;
   logic calm;

   // Predictor state: a private copy of the palette, counters and format
   logic [23:0]                       pal_rgb [PALETTE_ENTRIES];
   logic [fbrgb_pkg::BYTE_ROW_W-1:0]  m_byte_in_row;
   logic [fbrgb_pkg::PIXEL_X_W-1:0]   m_pixel_x;
   logic [fbrgb_pkg::ROW_COUNT_W-1:0] m_row;
   logic [23:0]                       m_held;
   logic [1:0]                        m_phase;
   fbrgb_pkg::cfg_type                m_cfg;

   // Pixels produced by the byte being predicted
   fbrgb_pkg::rsp_payload_type byte_pixels [8];
   int                         byte_count;

   framebuffer_to_rgb_pixel_unpacker_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Long stretch with no idling on either channel
   assign calm = (cycle_count >= CALM_START) && (cycle_count < CALM_END);

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic int unsigned eff_width();
      return (m_cfg.active_width > MAX_WIDTH) ? MAX_WIDTH : m_cfg.active_width;
   endfunction

   function automatic int unsigned eff_height();
      return (m_cfg.active_height > MAX_HEIGHT) ? MAX_HEIGHT : m_cfg.active_height;
   endfunction

   function automatic logic [23:0] palette_color(input logic [7:0] idx);
      // Indexes past the palette read as black
      return (int'(idx) < PALETTE_ENTRIES) ? pal_rgb[idx] : 24'h0;
   endfunction

   task automatic reset_model();
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         pal_rgb[i] = {3{8'(255 - i)}};
      end
      m_byte_in_row = '0;
      m_pixel_x     = '0;
      m_row         = '0;
      m_held        = '0;
      m_phase       = '0;
      m_cfg.depth_mode       = fbrgb_pkg::DEPTH_MODE_RESET;
      m_cfg.active_width     = fbrgb_pkg::FRAME_WIDTH_RESET;
      m_cfg.active_height    = fbrgb_pkg::FRAME_HEIGHT_RESET;
      m_cfg.row_stride_bytes = fbrgb_pkg::ROW_STRIDE_RESET;
   endtask

   // Place one pixel at the current column unless the row is already full
   task automatic put_pixel(input logic [23:0] rgb);
      int unsigned w;
      int unsigned h;
      w = eff_width();
      h = eff_height();
      if (int'(m_pixel_x) < w && byte_count < 8) begin
         byte_pixels[byte_count].red       = rgb[23:16];
         byte_pixels[byte_count].green     = rgb[15:8];
         byte_pixels[byte_count].blue      = rgb[7:0];
         byte_pixels[byte_count].run_last  = 1'b0;
         byte_pixels[byte_count].row_end   = (int'(m_pixel_x) + 1 == w);
         byte_pixels[byte_count].frame_end = (int'(m_pixel_x) + 1 == w) &&
                                             (int'(m_row) + 1 == h);
         m_pixel_x  = m_pixel_x + 1'b1;
         byte_count = byte_count + 1;
      end
   endtask

   task automatic predict_pixels(input fbrgb_pkg::req_payload_type t);
      int          bits;
      int          ppb;
      int          mask;
      logic [7:0]  b;
      logic [15:0] p;
      b = t.source_byte;
      byte_count = 0;
      if (t.req_type == fbrgb_pkg::REQ_PALETTE_WRITE) begin
         if (int'(t.entry_index) < PALETTE_ENTRIES) begin
            pal_rgb[t.entry_index] = {t.entry_red, t.entry_green, t.entry_blue};
         end
         return;
      end
      if (m_cfg.depth_mode <= fbrgb_pkg::MODE_8BPP) begin
         bits = 1 << m_cfg.depth_mode;
         ppb  = 8 >> m_cfg.depth_mode;
         mask = (1 << bits) - 1;
         for (int k = 0; k < ppb; k++) begin
            put_pixel(palette_color(8'((int'(b) >> (8 - bits * (k + 1))) & mask)));
         end
      end else if (m_cfg.depth_mode == fbrgb_pkg::MODE_RGB555) begin
         // Any nonzero phase completes the pair, even one left by ARGB
         if (m_phase == 2'd0) begin
            m_held  = {16'h0, b};
            m_phase = 2'd1;
         end else begin
            p = {m_held[7:0], b};
            put_pixel({p[14:10], 3'b000, p[9:5], 3'b000, p[4:0], 3'b000});
            m_held  = '0;
            m_phase = 2'd0;
         end
      end else if (m_cfg.depth_mode == fbrgb_pkg::MODE_ARGB8888) begin
         case (m_phase)
            2'd0: begin
               m_held  = '0;
               m_phase = 2'd1;
            end
            2'd1: begin
               m_held  = {b, 16'h0};
               m_phase = 2'd2;
            end
            2'd2: begin
               m_held  = {m_held[23:16], b, 8'h0};
               m_phase = 2'd3;
            end
            default: begin
               put_pixel({m_held[23:8], b});
               m_held  = '0;
               m_phase = 2'd0;
            end
         endcase
      end
      if (byte_count > 0) begin
         byte_pixels[byte_count - 1].run_last = 1'b1;
      end
      for (int k = 0; k < byte_count; k++) begin
         pixels_due.insert(pixels_due.size(), byte_pixels[k]);
      end
      // Row advance drops any partly gathered pixel
      if (int'(m_byte_in_row) + 1 >= int'(m_cfg.row_stride_bytes)) begin
         m_byte_in_row = '0;
         m_pixel_x     = '0;
         m_phase       = '0;
         m_held        = '0;
         if (int'(m_row) + 1 >= eff_height()) begin
            m_row = '0;
         end else begin
            m_row = m_row + 1'b1;
         end
      end else begin
         m_byte_in_row = m_byte_in_row + 1'b1;
      end
   endtask

   // ------------------------------------------------------------------
   // Request driver: present the backlog, predict on every transfer
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_pixels(req_payload);
         end
         // Hold a stalled payload; otherwise pick the next one or idle
         if (!req_valid || !req_stall) begin
            if (req_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_valid   <= 1'b1;
               req_payload <= req_backlog.pop_front();
            end else begin
               req_valid   <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result monitor: compare each transfer with the oldest prediction
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         if (error_count <= MAX_REPORTS) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      fbrgb_pkg::rsp_payload_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pixels_due.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t ns: unexpected pixel, expected none, actual %h",
                           $time, rsp_payload);
               end
            end else begin
               want = pixels_due.pop_front();
               check_field("red",       want.red,       rsp_payload.red);
               check_field("green",     want.green,     rsp_payload.green);
               check_field("blue",      want.blue,      rsp_payload.blue);
               check_field("run_last",  want.run_last,  rsp_payload.run_last);
               check_field("row_end",   want.row_end,   rsp_payload.row_end);
               check_field("frame_end", want.frame_end, rsp_payload.frame_end);
            end
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // Hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic queue_byte(input logic [7:0] b);
      fbrgb_pkg::req_payload_type t;
      t.req_type    = fbrgb_pkg::REQ_FB_BYTE;
      t.source_byte = b;
      // Fields the block must ignore for a framebuffer byte
      t.entry_index = 8'($urandom);
      t.entry_red   = 8'($urandom);
      t.entry_green = 8'($urandom);
      t.entry_blue  = 8'($urandom);
      req_backlog.insert(req_backlog.size(), t);
   endtask

   task automatic queue_entry(input logic [7:0] idx, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b);
      fbrgb_pkg::req_payload_type t;
      t.req_type    = fbrgb_pkg::REQ_PALETTE_WRITE;
      t.source_byte = 8'($urandom);
      t.entry_index = idx;
      t.entry_red   = r;
      t.entry_green = g;
      t.entry_blue  = b;
      req_backlog.insert(req_backlog.size(), t);
   endtask

   function automatic logic [7:0] random_source_byte();
      if ($urandom_range(0, 3) == 0) begin
         return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      return 8'($urandom);
   endfunction

   // Hold the sender until the backlog is gone and every pixel has come back;
   // look between edges so the driver and monitor have both settled
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (req_backlog.size() != 0 || req_valid || pixels_due.size() != 0);
   endtask

   task automatic write_csr(input logic [fbrgb_pkg::CSR_INDEX_W-1:0] idx,
                            input int unsigned value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= fbrgb_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         fbrgb_pkg::CSR_DEPTH_MODE:   m_cfg.depth_mode    = 3'(value);
         fbrgb_pkg::CSR_FRAME_WIDTH:  m_cfg.active_width  = fbrgb_pkg::PIXEL_X_W'(value);
         fbrgb_pkg::CSR_FRAME_HEIGHT: m_cfg.active_height = fbrgb_pkg::ROW_COUNT_W'(value);
         fbrgb_pkg::CSR_ROW_STRIDE:
            m_cfg.row_stride_bytes = fbrgb_pkg::BYTE_ROW_W'(value);
         default: begin
         end
      endcase
   endtask

   // Reprogram the format only once the block has gone quiet
   task automatic set_format(input logic [2:0] mode, input int unsigned width,
                             input int unsigned height, input int unsigned stride);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(fbrgb_pkg::CSR_DEPTH_MODE,   mode);
      write_csr(fbrgb_pkg::CSR_FRAME_WIDTH,  width);
      write_csr(fbrgb_pkg::CSR_FRAME_HEIGHT, height);
      write_csr(fbrgb_pkg::CSR_ROW_STRIDE,   stride);
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      int          random_items;
      int          phase_items;
      int          bits;
      int          need;
      int unsigned width;
      int unsigned height;
      int unsigned stride;
      logic [2:0]  mode;

      reset_model();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset format (ARGB): one pixel from four bytes of opposite extremes
      queue_byte(8'hFF);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(8'h00);
      // Overwrite the two ends of the gray ramp
      queue_entry(8'h00, 8'h00, 8'hFF, 8'h00);
      queue_entry(8'hFF, 8'hFF, 8'h00, 8'hFF);

      // 1 bpp, 12 wide, 2 rows, third byte of each row is padding
      set_format(fbrgb_pkg::MODE_1BPP, 12, 2, 3);
      queue_byte(8'h80);
      queue_byte(8'h7F);
      queue_byte(8'h55);
      queue_byte(8'hFF);
      queue_byte(8'h00);
      queue_byte(8'hAA);

      // 2 bpp, one byte per row and one row per frame
      set_format(fbrgb_pkg::MODE_2BPP, 4, 1, 1);
      queue_byte(8'h1B);
      queue_byte(8'hE4);

      // 4 bpp with zero height: rows end but the frame never does
      set_format(fbrgb_pkg::MODE_4BPP, 2, 0, 1);
      queue_byte(8'h0F);
      queue_byte(8'hF0);

      // 8 bpp with zero width: nothing comes out
      set_format(fbrgb_pkg::MODE_8BPP, 0, 3, 2);
      queue_byte(8'h00);
      queue_byte(8'hFF);

      // RGB555 with a stride shorter than the width: no row end flag
      set_format(fbrgb_pkg::MODE_RGB555, 3, 2, 2);
      queue_byte(8'h7F);
      queue_byte(8'hFF);

      // Unused depth codes only advance the counters
      set_format(MODE_UNUSED_6, 4, 2, 2);
      queue_byte(8'hC3);
      set_format(MODE_UNUSED_7, 4, 2, 2);
      queue_byte(8'h3C);

      // Leave ARGB half gathered, then let RGB555 finish the pixel
      set_format(fbrgb_pkg::MODE_ARGB8888, 8, 4, 64);
      queue_byte(8'h12);
      queue_byte(8'h34);
      set_format(fbrgb_pkg::MODE_RGB555, 8, 4, 64);
      queue_byte(8'h56);

      // Width and height above their caps
      set_format(fbrgb_pkg::MODE_1BPP, 4095, 2047, 4);
      repeat (8) queue_byte(random_source_byte());

      // Largest legal format
      set_format(fbrgb_pkg::MODE_ARGB8888, 2560, 1600, 10240);
      repeat (12) queue_byte(random_source_byte());

      // Smallest legal format
      set_format(fbrgb_pkg::MODE_8BPP, 1, 1, 1);
      repeat (6) queue_byte(random_source_byte());

      // Random formats, mostly well-formed rows, now and then a short stride
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 15) < 14) begin
            mode = 3'($urandom_range(0, 5));
         end else begin
            mode = $urandom_range(0, 1) ? MODE_UNUSED_6 : MODE_UNUSED_7;
         end
         width  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 20);
         height = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
         if (mode <= fbrgb_pkg::MODE_8BPP)           bits = 1 << mode;
         else if (mode == fbrgb_pkg::MODE_RGB555)    bits = 16;
         else if (mode == fbrgb_pkg::MODE_ARGB8888)  bits = 32;
         else                                        bits = 8;
         need = (int'(width) * bits + 7) / 8;
         if ($urandom_range(0, 7) == 0) begin
            stride = $urandom_range(0, need);
         end else begin
            stride = need + $urandom_range(0, 2);
         end
         set_format(mode, width, height, stride);

         phase_items = $urandom_range(20, 50);
         for (int i = 0; i < phase_items; i++) begin
            // Drop the sender halfway until every pixel has come back
            if (i == phase_items / 2) wait_drained();
            if ($urandom_range(0, 99) < 15) begin
               queue_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
               queue_byte(random_source_byte());
            end
         end
         random_items += phase_items;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pixels_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
